>>> rtl/scf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scf_pkg - shared definitions for the substring count and find core
// Register indexes, field widths, default sizes and the pattern byte select.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;

  localparam int PAT_BYTES = 16;
  localparam int PAT_W     = 8 * PAT_BYTES;
  localparam int LEN_W     = 5;
  localparam int WSTART_W  = 16;
  localparam int WEND_W    = 17;
  localparam int COUNT_W   = 17;
  localparam int FPOS_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = CFG_IDX_W'(4);

  // Pattern byte k; bytes past the stored sixteen read as zero.
  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                          input logic [LEN_W-1:0] k);
    logic [7:0] b;
    b = pat[k[3:0]*8 +: 8];
    return k[4] ? 8'd0 : b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/scf_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scf_match - byte history and parallel pattern compare
// Keeps the newest text bytes and compares them, together with the incoming
// byte, against the pattern aligned so that its last byte meets the newest.
// ----------------------------------------------------------------------------
module scf_match #(
  parameter int MAX_PATTERN = scf_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic [7:0]                 text_byte,
  input  wire logic [scf_pkg::PAT_W-1:0]  pattern,
  input  wire logic [scf_pkg::LEN_W-1:0]  pattern_length,
  output logic                            hit
);

  logic [7:0]             recent [MAX_PATTERN];
  logic [7:0]             cand   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_ok;

  always_ff @(posedge clk) begin
    if (shift) begin
      recent[0] <= text_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
    logic                        lane_on;
    logic [scf_pkg::LEN_W-1:0]   k;

    if (i == 0) begin : g_new
      assign cand[i] = text_byte;
    end else begin : g_old
      assign cand[i] = recent[i-1];
    end

    assign lane_on    = 32'(pattern_length) > i;
    assign k          = pattern_length - scf_pkg::LEN_W'(i) - scf_pkg::LEN_W'(1);
    assign lane_ok[i] = !lane_on || (cand[i] == scf_pkg::pat_byte(pattern, k));
  end

  assign hit = &lane_ok;

endmodule
`default_nettype wire

>>> rtl/substring_count_and_find_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// substring_count_and_find_core - streaming substring counter and finder
// Counts greedy non-overlapping matches of a configured pattern that lie
// wholly inside a window of the text and reports the first match start.
//
//   channel   signals                                   direction
//   in        in_valid, in_stall, text_byte, is_last    request in
//   out       out_valid, out_stall, match_count,
//             found, first_position                     request out
//   cfg       cfg_write, cfg_index, cfg_data            write only
//
// One text byte per cycle while in_stall is low; a request is held in the input
// register and its result, on the last byte only, is taken from there into the output
// register. The pattern compare and count update sit between the two.
// Only a last byte waiting on a full, stalled output register stalls input.
// Reset clears all stream state; registers return to their reset values.
// ----------------------------------------------------------------------------
module substring_count_and_find_core #(
  parameter int MAX_PATTERN = scf_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = scf_pkg::MAX_TEXT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     text_byte,
  input  wire logic                           is_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [scf_pkg::COUNT_W-1:0]         match_count,
  output logic                                found,
  output logic [scf_pkg::FPOS_W-1:0]          first_position,
  input  wire logic                           cfg_write,
  input  wire logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scf_pkg::CFG_W-1:0]      cfg_data
);

  localparam int POS_W = $clog2(MAX_TEXT + 1);
  localparam int CW    = (POS_W > scf_pkg::WEND_W) ? POS_W : scf_pkg::WEND_W;

  // configuration
  logic [scf_pkg::PAT_W-1:0]    pattern;
  logic [scf_pkg::LEN_W-1:0]    pattern_length;
  logic [scf_pkg::WSTART_W-1:0] window_start;
  logic [scf_pkg::WEND_W-1:0]   window_end;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       s1_fire;

  // stream state
  logic [POS_W-1:0]            byte_position;
  logic [POS_W-1:0]            byte_position_next;
  logic [scf_pkg::COUNT_W-1:0] matches_seen;
  logic [scf_pkg::COUNT_W-1:0] matches_seen_next;
  logic [POS_W-1:0]            next_allowed_start;
  logic [POS_W-1:0]            next_allowed_start_next;
  logic                        first_seen;
  logic                        first_seen_next;
  logic [scf_pkg::FPOS_W-1:0]  first_start;
  logic [scf_pkg::FPOS_W-1:0]  first_start_next;

  logic             take;
  logic             hit;
  logic             len_ok;
  logic             accept_match;
  logic [POS_W-1:0] pos_inc;
  logic [CW-1:0]    start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= '0;
      window_start   <= '0;
      window_end     <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        scf_pkg::REG_PATTERN_LOW:  pattern[63:0]   <= cfg_data;
        scf_pkg::REG_PATTERN_HIGH: pattern[127:64] <= cfg_data;
        scf_pkg::REG_PATTERN_LEN:  pattern_length  <= cfg_data[scf_pkg::LEN_W-1:0];
        scf_pkg::REG_WINDOW_START: window_start    <= cfg_data[scf_pkg::WSTART_W-1:0];
        scf_pkg::REG_WINDOW_END:   window_end      <= cfg_data[scf_pkg::WEND_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go    = !s1_last || !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_byte <= text_byte;
      s1_last <= is_last;
    end
  end

  scf_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk            (clk),
    .shift          (s1_fire && take),
    .text_byte      (s1_byte),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .hit            (hit)
  );

  always_comb begin
    take    = byte_position < POS_W'(MAX_TEXT);
    pos_inc = byte_position + POS_W'(1);
    len_ok  = (pattern_length != '0) && (32'(pattern_length) <= MAX_PATTERN) &&
              (CW'(pos_inc) >= CW'(pattern_length));
    start   = CW'(pos_inc) - CW'(pattern_length);
    accept_match = take && len_ok && hit &&
                   (start >= CW'(window_start)) &&
                   (start >= CW'(next_allowed_start)) &&
                   !(!window_end[scf_pkg::WEND_W-1] &&
                     (CW'(pos_inc) > CW'(window_end)));

    byte_position_next      = take ? pos_inc : byte_position;
    matches_seen_next       = matches_seen;
    next_allowed_start_next = next_allowed_start;
    first_seen_next         = first_seen;
    first_start_next        = first_start;
    if (accept_match) begin
      if (matches_seen < scf_pkg::COUNT_MAX) begin
        matches_seen_next = matches_seen + scf_pkg::COUNT_W'(1);
      end
      next_allowed_start_next = pos_inc;
      if (!first_seen) begin
        first_seen_next  = 1'b1;
        first_start_next = start[scf_pkg::FPOS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      matches_seen       <= '0;
      next_allowed_start <= '0;
      first_seen         <= 1'b0;
      first_start        <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        byte_position      <= '0;
        matches_seen       <= '0;
        next_allowed_start <= '0;
        first_seen         <= 1'b0;
        first_start        <= '0;
      end else begin
        byte_position      <= byte_position_next;
        matches_seen       <= matches_seen_next;
        next_allowed_start <= next_allowed_start_next;
        first_seen         <= first_seen_next;
        first_start        <= first_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      match_count    <= matches_seen_next;
      found          <= first_seen_next;
      first_position <= first_seen_next ? first_start_next : '0;
    end
  end

  a_notfound_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_count == '0 && first_position == '0)
    else $error("result without match carries a count or position");

  a_found_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> match_count != '0)
    else $error("match reported with zero count");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    matches_seen <= scf_pkg::COUNT_MAX)
    else $error("match counter past saturation");

  a_allowed_order: assert property (@(posedge clk) disable iff (rst)
    next_allowed_start <= byte_position)
    else $error("next allowed start ahead of text position");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

>>> tb/tb_substring_count_and_find_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_count_and_find_core - self-checking bench for the substring core
// Streams texts into the core one byte per request and predicts each end-of-text
// result: non-overlapping pattern matches inside the search window, the found
// flag and the first match start. A short table covers reset values, window
// limits, empty and overlong patterns and ignored register indexes. Random
// phases follow with random settings, pattern-rich texts, random idling on both
// sides and a long output hold that backs the core up.
// ----------------------------------------------------------------------------
module tb_substring_count_and_find_core;

  typedef struct packed {
    logic [scf_pkg::COUNT_W-1:0] total;
    logic                        hit;
    logic [scf_pkg::FPOS_W-1:0]  start;
  } tally_t;

  typedef struct packed {
    logic                          is_cfg;
    logic [scf_pkg::CFG_IDX_W-1:0] idx;
    logic [scf_pkg::CFG_W-1:0]     data;
    logic [7:0]                    b;
    logic                          last;
    logic                          typed_ok;
    tally_t                        want;
  } row_t;

  localparam logic [scf_pkg::CFG_IDX_W-1:0] REG_SPARE = '1;
  localparam tally_t NO_HIT = '0;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 950;
  localparam int CALM_AFTER = 800;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    text_byte = 8'h00;
  logic                          is_last = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [scf_pkg::COUNT_W-1:0]   match_count;
  logic                          found;
  logic [scf_pkg::FPOS_W-1:0]    first_position;
  logic                          cfg_write = 1'b0;
  logic [scf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scf_pkg::CFG_W-1:0]     cfg_data = '0;

  substring_count_and_find_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .match_count    (match_count),
    .found          (found),
    .first_position (first_position),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // search settings as the core should hold them
  logic [63:0]                  pat_lo;
  logic [63:0]                  pat_hi;
  logic [scf_pkg::LEN_W-1:0]    pat_len;
  logic [scf_pkg::WSTART_W-1:0] win_start;
  logic [scf_pkg::WEND_W-1:0]   win_end;

  // per-text search state
  logic [7:0]                  hist [scf_pkg::MAX_PATTERN_DEF];
  logic [16:0]                 text_pos;
  logic [scf_pkg::COUNT_W-1:0] tally;
  logic [16:0]                 resume_at;
  logic                        first_hit;
  logic [scf_pkg::FPOS_W-1:0]  first_at;

  tally_t      tally_q[$];
  int          errors = 0;
  int          idle_pct = 0;
  bit          hold_pending = 1'b0;
  int unsigned bytes_sent = 0;

  row_t plan[$] = '{
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'h00, 1'b1, 1'b1, NO_HIT},
    '{1'b1, scf_pkg::REG_PATTERN_LOW,  64'hFFFF,  8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b1, scf_pkg::REG_PATTERN_LEN,  64'd2,     8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, '{17'd2, 1'b1, 16'd0}},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, NO_HIT},
    '{1'b1, scf_pkg::REG_WINDOW_START, 64'd1,     8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, '{17'd1, 1'b1, 16'd1}},
    '{1'b1, scf_pkg::REG_WINDOW_END,   64'd3,     8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, '{17'd1, 1'b1, 16'd1}},
    '{1'b1, scf_pkg::REG_WINDOW_START, 64'd5,     8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, NO_HIT},
    '{1'b1, scf_pkg::REG_WINDOW_START, 64'd0,     8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b1, scf_pkg::REG_WINDOW_END,   64'h10000, 8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, '{17'd1, 1'b1, 16'd0}},
    '{1'b1, scf_pkg::REG_PATTERN_LEN,  64'd31,    8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, NO_HIT},
    '{1'b1, REG_SPARE,                 '1,        8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b1, scf_pkg::REG_PATTERN_LEN,  64'd2,     8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, '{17'd1, 1'b1, 16'd0}},
    '{1'b1, scf_pkg::REG_WINDOW_END,   64'hFFFF,  8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b1, scf_pkg::REG_WINDOW_START, 64'hFFFF,  8'h00, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b0, 1'b0, NO_HIT},
    '{1'b0, scf_pkg::REG_PATTERN_LOW,  64'd0,     8'hFF, 1'b1, 1'b1, NO_HIT}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic void clear_text();
    foreach (hist[i]) hist[i] = 8'h00;
    text_pos  = '0;
    tally     = '0;
    resume_at = '0;
    first_hit = 1'b0;
    first_at  = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [scf_pkg::PAT_W-1:0] pat;
    int unsigned len, pos, start;
    bit hit;
    if (text_pos >= 17'(scf_pkg::MAX_TEXT_DEF)) return;
    for (int i = scf_pkg::MAX_PATTERN_DEF - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = b;
    pos = text_pos;
    text_pos = text_pos + 17'd1;
    len = pat_len;
    if (len == 0 || len > scf_pkg::MAX_PATTERN_DEF || pos + 1 < len) return;
    pat = {pat_hi, pat_lo};
    hit = 1'b1;
    for (int i = 0; i < len; i++)
      if (hist[i] != pat[(len - 1 - i) * 8 +: 8]) hit = 1'b0;
    if (!hit) return;
    start = pos + 1 - len;
    if (start < win_start || start < resume_at) return;
    if (!win_end[scf_pkg::WEND_W-1] && pos + 1 > win_end[15:0]) return;
    if (tally < scf_pkg::COUNT_MAX) tally = tally + 1'b1;
    resume_at = 17'(pos + 1);
    if (!first_hit) begin
      first_hit = 1'b1;
      first_at  = 16'(start);
    end
  endfunction

  function automatic bit predict_request(input logic [7:0] b, input logic last,
                                         output tally_t r);
    r = '0;
    absorb_byte(b);
    if (!last) return 1'b0;
    r.total = tally;
    r.hit   = first_hit;
    r.start = first_hit ? first_at : '0;
    clear_text();
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [scf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scf_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      scf_pkg::REG_PATTERN_LOW:  pat_lo = val;
      scf_pkg::REG_PATTERN_HIGH: pat_hi = val;
      scf_pkg::REG_PATTERN_LEN:  pat_len = val[scf_pkg::LEN_W-1:0];
      scf_pkg::REG_WINDOW_START: win_start = val[scf_pkg::WSTART_W-1:0];
      scf_pkg::REG_WINDOW_END:   win_end = val[scf_pkg::WEND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit typed_ok, input tally_t typed);
    bit stalled;
    tally_t r;
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    is_last   <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (predict_request(b, last, r)) tally_q.push_back(typed_ok ? typed : r);
  endtask

  task automatic send_text(input int want_len, input bit noisy);
    logic [7:0] bytes_q[$];
    logic [scf_pkg::PAT_W-1:0] pat;
    int k, used, pick;
    pat = {pat_hi, pat_lo};
    used = (pat_len > scf_pkg::PAT_BYTES) ? scf_pkg::PAT_BYTES : int'(pat_len);
    while (bytes_q.size() < want_len) begin
      pick = $urandom_range(0, 9);
      if (noisy || used == 0 || pick < 2) begin
        bytes_q.push_back(8'($urandom));
      end else if (pick < 5 && pat_len <= scf_pkg::PAT_BYTES) begin
        for (k = 0; k < used; k++) bytes_q.push_back(pat[k*8 +: 8]);
      end else if (pick < 6 && used > 1) begin
        // broken copy: a prefix only
        for (k = 0; k < $urandom_range(1, used - 1); k++) bytes_q.push_back(pat[k*8 +: 8]);
      end else begin
        k = $urandom_range(0, used - 1);
        bytes_q.push_back(pat[k*8 +: 8]);
      end
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, NO_HIT);
    bytes_sent += bytes_q.size();
  endtask

  // output side: random stall bursts, and one long hold on request
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  bit     took = 1'b0;
  tally_t seen = '0;

  always @(negedge clk) begin
    took = (out_valid === 1'b1) && !out_stall && !rst;
    seen = {match_count, found, first_position};
  end

  always @(posedge clk) begin
    tally_t want;
    if (took) begin
      if (tally_q.size() == 0) begin
        flag_mismatch("result with no request pending");
      end else begin
        want = tally_q.pop_front();
        if (seen.total !== want.total)
          flag_mismatch($sformatf("match_count %0d, want %0d", seen.total, want.total));
        if (seen.hit !== want.hit)
          flag_mismatch($sformatf("found %0b, want %0b", seen.hit, want.hit));
        if (seen.start !== want.start)
          flag_mismatch($sformatf("first_position %0d, want %0d", seen.start, want.start));
      end
    end
  end

  initial begin : limit
    #8_000_000;
    $display("substring_count_and_find_core verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [scf_pkg::PAT_W-1:0] word;
    logic [scf_pkg::WEND_W-1:0] wend;
    int k, n, phase, pick;
    pat_lo    = '0;
    pat_hi    = '0;
    pat_len   = '0;
    win_start = '0;
    win_end   = '1;
    clear_text();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_byte(plan[i].b, plan[i].last, plan[i].typed_ok, plan[i].want);
      end
    end

    phase = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      wait_idle();
      for (k = 0; k < scf_pkg::PAT_BYTES; k++)
        word[k*8 +: 8] = ($urandom_range(0, 1) != 0) ? 8'h61 + 8'($urandom_range(0, 1))
                                                     : 8'($urandom);
      write_reg(scf_pkg::REG_PATTERN_LOW, word[63:0]);
      write_reg(scf_pkg::REG_PATTERN_HIGH, word[127:64]);
      pick = $urandom_range(0, 19);
      if (pick < 2)       n = 0;
      else if (pick < 4)  n = scf_pkg::PAT_BYTES;
      else if (pick < 5)  n = $urandom_range(scf_pkg::PAT_BYTES + 1, 31);
      else if (pick < 14) n = $urandom_range(1, 3);
      else                n = $urandom_range(4, scf_pkg::PAT_BYTES - 1);
      write_reg(scf_pkg::REG_PATTERN_LEN, scf_pkg::CFG_W'(n));
      pick = $urandom_range(0, 19);
      if (pick < 12)      n = 0;
      else if (pick < 17) n = $urandom_range(1, 12);
      else if (pick < 19) n = $urandom_range(13, 40);
      else                n = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(41, 65535);
      write_reg(scf_pkg::REG_WINDOW_START, scf_pkg::CFG_W'(n));
      pick = $urandom_range(0, 9);
      if (pick < 4)      wend = '1;
      else if (pick < 7) wend = scf_pkg::WEND_W'($urandom_range(0, 40));
      else if (pick < 8) wend = 17'h0FFFF;
      else if (pick < 9) wend = {1'b1, 16'($urandom)};
      else               wend = {1'b0, 16'($urandom)};
      write_reg(scf_pkg::REG_WINDOW_END, scf_pkg::CFG_W'(wend));
      if ($urandom_range(0, 4) == 0)
        write_reg(scf_pkg::CFG_IDX_W'(scf_pkg::REG_WINDOW_END + $urandom_range(1, 3)),
                  {$urandom, $urandom});

      if (phase == 3) begin
        // back the core up behind a held output
        idle_pct = 0;
        hold_pending = 1'b1;
        repeat (24) send_text($urandom_range(1, 2), 1'b0);
      end
      pick = $urandom_range(0, 2);
      idle_pct = (bytes_sent > CALM_AFTER) ? 0 : (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      repeat ($urandom_range(3, 8)) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
        send_text(n, $urandom_range(0, 6) == 0);
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0 && tally_q.size() == 0) begin
      $display("substring_count_and_find_core verification clean");
    end else begin
      $display("substring_count_and_find_core verification failed");
    end
    $finish;
  end

endmodule
